@@ rtl/core/sbl_pkg.sv @@
// Shared types, constants and register codes for the Sobel edge magnitude block.
// No dependencies; all files in rtl/core but sbl_line_ram refer to this package by scope.
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

    // Frame limits and channel layout
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int CHANNEL_BITS = 8;
    localparam int NCH          = 3;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Counter widths follow from the frame limits.
    localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Arithmetic widths: a weighted column sum is at most 4 * (2^CHANNEL_BITS - 1).
    localparam int G_W     = CHANNEL_BITS + 2;
    localparam int SUM_W   = 2 * G_W + 1;
    localparam int ROOT_W  = G_W + 1;
    localparam int TRIAL_W = SUM_W + 1;

    // Pixel and line store word widths
    localparam int PIX_W  = NCH * CHANNEL_BITS;
    localparam int LINE_W = 2 * PIX_W;

    // Fixed field widths of the ports
    localparam int IN_CH_W    = 8;
    localparam int MAG_W      = 11;
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    // Register reset values
    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd1024;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef chan_t [NCH-1:0]         pix_t;
    typedef logic [LINE_W-1:0]       line_t;
    typedef logic [COL_W-1:0]        col_t;
    typedef logic [ROW_W-1:0]        row_t;
    typedef logic [G_W-1:0]          grad_t;
    typedef logic [SUM_W-1:0]        sum_t;
    typedef sum_t [NCH-1:0]          sum_vec_t;
    typedef logic [ROOT_W-1:0]       root_t;
    typedef root_t [NCH-1:0]         root_vec_t;
    typedef logic [TRIAL_W-1:0]      trial_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic [WCFG_W-1:0]       wcfg_t;
    typedef logic [HCFG_W-1:0]       hcfg_t;

    // Input word: one RGB pixel
    typedef struct packed {
        logic [IN_CH_W-1:0] red;
        logic [IN_CH_W-1:0] green;
        logic [IN_CH_W-1:0] blue;
    } pixel_word_t;

    // Output word: per-channel magnitudes and end-of-frame mark
    typedef struct packed {
        mag_t red_mag;
        mag_t green_mag;
        mag_t blue_mag;
        logic frame_last;
    } mag_word_t;

    // Control that travels with a pixel into the window stage
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } ctl_t;

    // Control that travels with a result through the arithmetic stages
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

@@ rtl/core/sbl_line_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Holds the two previous image rows; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module sbl_line_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/sbl_window.sv @@
// 3x3 neighborhood registers, Sobel gradients and sum of squares per channel.
// Depends on sbl_pkg; three pipeline stages that move together on advance.
`timescale 1ns / 1ps
`default_nettype none

module sbl_window (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire sbl_pkg::ctl_t     ctl,
    input  wire sbl_pkg::pix_t     cur,
    input  wire sbl_pkg::pix_t     p1,
    input  wire sbl_pkg::pix_t     p2,
    output sbl_pkg::tag_t          tag_out,
    output sbl_pkg::sum_vec_t      sum_out
);

    // Window: first index is the row (0 top), second the column (0 left).
    sbl_pkg::pix_t     win_reg [3][3];
    sbl_pkg::tag_t     tag_a_reg;
    sbl_pkg::tag_t     tag_b_reg;
    sbl_pkg::tag_t     tag_c_reg;
    sbl_pkg::grad_t    gx_reg   [sbl_pkg::NCH];
    sbl_pkg::grad_t    gy_reg   [sbl_pkg::NCH];
    sbl_pkg::grad_t    gx_next  [sbl_pkg::NCH];
    sbl_pkg::grad_t    gy_next  [sbl_pkg::NCH];
    sbl_pkg::sum_vec_t sum_reg;
    sbl_pkg::sum_vec_t sum_next;

    // Shift the window by one column for every pixel, emitted or not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '{default: '0};
        end
        else if (advance && ctl.valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= p2;
            win_reg[1][2] <= p1;
            win_reg[2][2] <= cur;
        end
    end

    // Weighted column and row sums, then absolute differences.
    always_comb
    begin
        sbl_pkg::grad_t left;
        sbl_pkg::grad_t right;
        sbl_pkg::grad_t top;
        sbl_pkg::grad_t bottom;
        for (int c = 0; c < sbl_pkg::NCH; c++)
        begin
            left   = sbl_pkg::grad_t'(win_reg[0][0][c])
                   + (sbl_pkg::grad_t'(win_reg[1][0][c]) << 1)
                   + sbl_pkg::grad_t'(win_reg[2][0][c]);
            right  = sbl_pkg::grad_t'(win_reg[0][2][c])
                   + (sbl_pkg::grad_t'(win_reg[1][2][c]) << 1)
                   + sbl_pkg::grad_t'(win_reg[2][2][c]);
            top    = sbl_pkg::grad_t'(win_reg[0][0][c])
                   + (sbl_pkg::grad_t'(win_reg[0][1][c]) << 1)
                   + sbl_pkg::grad_t'(win_reg[0][2][c]);
            bottom = sbl_pkg::grad_t'(win_reg[2][0][c])
                   + (sbl_pkg::grad_t'(win_reg[2][1][c]) << 1)
                   + sbl_pkg::grad_t'(win_reg[2][2][c]);
            gx_next[c] = (left >= right) ? (left - right) : (right - left);
            gy_next[c] = (top >= bottom) ? (top - bottom) : (bottom - top);
        end
    end

    // Squares of the gradients, summed per channel.
    always_comb
    begin
        for (int c = 0; c < sbl_pkg::NCH; c++)
        begin
            sum_next[c] = sbl_pkg::sum_t'(gx_reg[c]) * sbl_pkg::sum_t'(gx_reg[c])
                        + sbl_pkg::sum_t'(gy_reg[c]) * sbl_pkg::sum_t'(gy_reg[c]);
        end
    end

    // Stage control: only emitting pixels carry a valid result onward.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else if (advance)
        begin
            tag_a_reg.valid <= ctl.valid && ctl.emit;
            tag_a_reg.last  <= ctl.last;
            tag_b_reg       <= tag_a_reg;
            tag_c_reg       <= tag_b_reg;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            sum_reg <= sum_next;
        end
    end

    assign tag_out = tag_c_reg;
    assign sum_out = sum_reg;

endmodule

`default_nettype wire

@@ rtl/core/sbl_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, all channels in parallel.
// Depends on sbl_pkg; stages move together on advance.
`timescale 1ns / 1ps
`default_nettype none

module sbl_isqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire sbl_pkg::tag_t      tag_in,
    input  wire sbl_pkg::sum_vec_t  sum_in,
    output sbl_pkg::tag_t           tag_out,
    output sbl_pkg::root_vec_t      root_out
);

    sbl_pkg::sum_vec_t  rem_reg  [sbl_pkg::ROOT_W];
    sbl_pkg::root_vec_t root_reg [sbl_pkg::ROOT_W];
    sbl_pkg::tag_t      tag_reg  [sbl_pkg::ROOT_W];

    for (genvar j = 0; j < sbl_pkg::ROOT_W; j++)
    begin : g_stage
        // Bit of the root decided in this stage
        localparam int B = sbl_pkg::ROOT_W - 1 - j;

        sbl_pkg::sum_vec_t  rem_src;
        sbl_pkg::root_vec_t root_src;
        sbl_pkg::tag_t      tag_src;
        sbl_pkg::sum_vec_t  rem_next;
        sbl_pkg::root_vec_t root_next;
        sbl_pkg::trial_t    trial [sbl_pkg::NCH];

        if (j == 0)
        begin : g_head
            assign rem_src  = sum_in;
            assign root_src = '0;
            assign tag_src  = tag_in;
        end
        else
        begin : g_body
            assign rem_src  = rem_reg[j-1];
            assign root_src = root_reg[j-1];
            assign tag_src  = tag_reg[j-1];
        end

        // Setting bit B grows the square by root * 2^(B+1) + 2^(2B).
        always_comb
        begin
            for (int c = 0; c < sbl_pkg::NCH; c++)
            begin
                trial[c] = (sbl_pkg::trial_t'(root_src[c]) << (B + 1))
                         + (sbl_pkg::trial_t'(1) << (2 * B));
                if (trial[c] <= sbl_pkg::trial_t'(rem_src[c]))
                begin
                    rem_next[c]  = rem_src[c] - trial[c][sbl_pkg::SUM_W-1:0];
                    root_next[c] = root_src[c] | (sbl_pkg::root_t'(1) << B);
                end
                else
                begin
                    rem_next[c]  = rem_src[c];
                    root_next[c] = root_src[c];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j] <= '0;
            end
            else if (advance)
            begin
                tag_reg[j] <= tag_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign tag_out  = tag_reg[sbl_pkg::ROOT_W-1];
    assign root_out = root_reg[sbl_pkg::ROOT_W-1];

endmodule

`default_nettype wire

@@ rtl/core/sobel_edge_magnitude.sv @@
// Streaming 3x3 Sobel gradient magnitude per RGB channel, pixels in raster order.
// Throughput: one pixel per cycle while pix_stall is low; the line store RAM is read and
// written once per pixel. A pixel passes the input, window, root and output registers.
// Reset clears the counters, the window, the pipeline valids and the output stage;
// both size registers return to 1024. Line store contents are not cleared.
// Depends on sbl_pkg, sbl_line_ram, sbl_window and sbl_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_magnitude (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pix_valid,
    output logic                                   pix_stall,
    input  wire sbl_pkg::pixel_word_t              pix_word,
    output logic                                   mag_valid,
    input  wire logic                              mag_stall,
    output sbl_pkg::mag_word_t                     mag_word,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sbl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sbl_pkg::wcfg_t      width_reg;
    sbl_pkg::wcfg_t      width_next;
    sbl_pkg::hcfg_t      height_reg;
    sbl_pkg::hcfg_t      height_next;
    sbl_pkg::col_t       col_reg;
    sbl_pkg::col_t       col_next;
    sbl_pkg::row_t       row_reg;
    sbl_pkg::row_t       row_next;
    sbl_pkg::col_t       last_col;
    sbl_pkg::row_t       last_row;

    logic                advance;
    logic                pix_accept;
    sbl_pkg::pix_t       cur_pix;
    sbl_pkg::ctl_t       ctl_reg;
    sbl_pkg::ctl_t       ctl_next;
    sbl_pkg::pix_t       pix_reg;
    sbl_pkg::col_t       addr_reg;

    sbl_pkg::line_t      rd_data;
    sbl_pkg::line_t      wr_data;
    sbl_pkg::pix_t       p1;
    sbl_pkg::pix_t       p2;

    sbl_pkg::tag_t       win_tag;
    sbl_pkg::sum_vec_t   win_sum;
    sbl_pkg::tag_t       res_tag;
    sbl_pkg::root_vec_t  res_root;
    logic                res_valid;
    sbl_pkg::mag_word_t  res_word;

    logic                load_out;
    logic                out_valid_reg;
    logic                out_valid_next;
    sbl_pkg::mag_word_t  out_word_reg;
    sbl_pkg::mag_word_t  out_word_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    sbl_pkg::mag_word_t  skid_word_reg;
    sbl_pkg::mag_word_t  skid_word_next;

    // The whole pipeline moves together unless the skid word is occupied.
    assign advance    = !skid_valid_reg;
    assign pix_stall  = skid_valid_reg;
    assign pix_accept = pix_valid && !pix_stall;
    assign cfg_ready  = 1'b1;

    // Effective frame size, saturated to the supported range.
    always_comb
    begin
        if (width_reg < sbl_pkg::wcfg_t'(3))
        begin
            last_col = sbl_pkg::col_t'(2);
        end
        else if (32'(width_reg) > sbl_pkg::MAX_WIDTH)
        begin
            last_col = sbl_pkg::col_t'(sbl_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            last_col = sbl_pkg::col_t'(width_reg - sbl_pkg::wcfg_t'(1));
        end

        if (height_reg < sbl_pkg::hcfg_t'(3))
        begin
            last_row = sbl_pkg::row_t'(2);
        end
        else if (32'(height_reg) > sbl_pkg::MAX_HEIGHT)
        begin
            last_row = sbl_pkg::row_t'(sbl_pkg::MAX_HEIGHT - 1);
        end
        else
        begin
            last_row = sbl_pkg::row_t'(height_reg - sbl_pkg::hcfg_t'(1));
        end
    end

    // Register writes restart the frame; otherwise each pixel steps the raster position.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sbl_pkg::CFG_WIDTH:
                begin
                    width_next = cfg_data[sbl_pkg::WCFG_W-1:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                sbl_pkg::CFG_HEIGHT:
                begin
                    height_next = cfg_data[sbl_pkg::HCFG_W-1:0];
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (pix_accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + sbl_pkg::row_t'(1);
            end
            else
            begin
                col_next = col_reg + sbl_pkg::col_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sbl_pkg::WIDTH_RESET;
            height_reg <= sbl_pkg::HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Input stage: channel extraction and the emit and end-of-frame decisions.
    always_comb
    begin
        cur_pix[sbl_pkg::CH_RED]   = sbl_pkg::chan_t'(pix_word.red);
        cur_pix[sbl_pkg::CH_GREEN] = sbl_pkg::chan_t'(pix_word.green);
        cur_pix[sbl_pkg::CH_BLUE]  = sbl_pkg::chan_t'(pix_word.blue);
        ctl_next.valid = pix_accept;
        ctl_next.emit  = (col_reg >= sbl_pkg::col_t'(2)) && (row_reg >= sbl_pkg::row_t'(2));
        ctl_next.last  = (col_reg == last_col) && (row_reg == last_row);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            pix_reg  <= cur_pix;
            addr_reg <= col_reg;
        end
    end

    // Line store: older row in the upper half, previous row in the lower half.
    // The entry read for a pixel is written back at the next advance; the next read
    // of that column is at least a full row later, so no forwarding is needed.
    assign p1      = rd_data[sbl_pkg::PIX_W-1:0];
    assign p2      = rd_data[sbl_pkg::LINE_W-1:sbl_pkg::PIX_W];
    assign wr_data = {p1, pix_reg};

    sbl_line_ram #(
        .DATA_W (sbl_pkg::LINE_W),
        .DEPTH  (sbl_pkg::MAX_WIDTH),
        .ADDR_W (sbl_pkg::COL_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (advance && ctl_reg.valid),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (pix_accept),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    sbl_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .ctl     (ctl_reg),
        .cur     (pix_reg),
        .p1      (p1),
        .p2      (p2),
        .tag_out (win_tag),
        .sum_out (win_sum)
    );

    sbl_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .tag_in   (win_tag),
        .sum_in   (win_sum),
        .tag_out  (res_tag),
        .root_out (res_root)
    );

    // Result word leaving the last root stage
    always_comb
    begin
        res_valid           = res_tag.valid && advance;
        res_word.red_mag    = sbl_pkg::mag_t'(res_root[sbl_pkg::CH_RED]);
        res_word.green_mag  = sbl_pkg::mag_t'(res_root[sbl_pkg::CH_GREEN]);
        res_word.blue_mag   = sbl_pkg::mag_t'(res_root[sbl_pkg::CH_BLUE]);
        res_word.frame_last = res_tag.last;
    end

    // Output register with a skid word behind it.
    always_comb
    begin
        load_out        = !out_valid_reg || !mag_stall;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_word_next  = res_word;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign mag_valid = out_valid_reg;
    assign mag_word  = out_word_reg;

endmodule

`default_nettype wire

@@ rtl/core/sbl_checker.sv @@
// Port-level checks for sobel_edge_magnitude, attached to it by a bind statement.
// Depends on sbl_pkg and on the top level's port names.
`timescale 1ns / 1ps
`default_nettype none

module sbl_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pix_stall,
    input wire logic               mag_valid,
    input wire logic               mag_stall,
    input wire sbl_pkg::mag_word_t mag_word
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mag_valid && mag_stall |=> mag_valid && $stable(mag_word))
        else $error("result word changed while stalled");

    // Input is held back only while a result word is waiting at the output.
    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> mag_valid)
        else $error("input stalled with no result word pending");

    // The input stalls only after the output was held in the previous cycle.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> $past(mag_valid && mag_stall))
        else $error("input stalled without a preceding output stall");

    // A new word after an empty output comes from a moving pipeline.
    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mag_valid) |-> $past(!pix_stall))
        else $error("result word appeared while the pipeline was frozen");

endmodule

bind sobel_edge_magnitude sbl_checker u_sbl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_stall (pix_stall),
    .mag_valid (mag_valid),
    .mag_stall (mag_stall),
    .mag_word  (mag_word)
);

`default_nettype wire
